### sv/ows_pkg.sv
// Shared types, constants and the arctangent table for the waveform shaper.
package ows_pkg;

  localparam int PHASE_BITS   = 24;
  localparam int SAMPLE_BITS  = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int IDX_BITS     = $clog2(CORDIC_STEPS);
  localparam int CW           = 34;
  localparam int OP_BITS      = 3;

  localparam logic signed [CW-1:0] X_START = CW'(64'sd652032874);
  localparam logic signed [CW-1:0] QUARTER = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF_C  = CW'(64'sd2147483648);
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX =
    SAMPLE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = ~S_MAX;

  typedef enum logic [OP_BITS-1:0] {
    OP_SINE     = 3'd0,
    OP_SAW      = 3'd1,
    OP_TRIANGLE = 3'd2,
    OP_PULSE    = 3'd3,
    OP_WHITE    = 3'd4
  } op_t;

  typedef struct packed {
    logic                          vld;
    logic                          sine;
    logic signed [SAMPLE_BITS-1:0] alt;
    logic signed [CW-1:0]          x;
    logic signed [CW-1:0]          y;
    logic signed [CW-1:0]          z;
  } cord_t;

  function automatic logic signed [CW-1:0] atan_turns(input logic [IDX_BITS-1:0] idx);
    logic signed [CW-1:0] v;
    unique case (idx)
      5'd0:    v = CW'(64'sd536870912);
      5'd1:    v = CW'(64'sd316933406);
      5'd2:    v = CW'(64'sd167458907);
      5'd3:    v = CW'(64'sd85004757);
      5'd4:    v = CW'(64'sd42667331);
      5'd5:    v = CW'(64'sd21354465);
      5'd6:    v = CW'(64'sd10679838);
      5'd7:    v = CW'(64'sd5340245);
      5'd8:    v = CW'(64'sd2670163);
      5'd9:    v = CW'(64'sd1335087);
      5'd10:   v = CW'(64'sd667544);
      5'd11:   v = CW'(64'sd333772);
      5'd12:   v = CW'(64'sd166886);
      5'd13:   v = CW'(64'sd83443);
      5'd14:   v = CW'(64'sd41722);
      5'd15:   v = CW'(64'sd20861);
      5'd16:   v = CW'(64'sd10430);
      5'd17:   v = CW'(64'sd5215);
      5'd18:   v = CW'(64'sd2608);
      5'd19:   v = CW'(64'sd1304);
      5'd20:   v = CW'(64'sd652);
      5'd21:   v = CW'(64'sd326);
      5'd22:   v = CW'(64'sd163);
      5'd23:   v = CW'(64'sd81);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/ows_front.sv
// Front stage: phase sum, simple waveforms and sine angle fold.
module ows_front
  import ows_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [PHASE_BITS-1:0]  phase,
  input  logic [PHASE_BITS-1:0]  phase_offset,
  input  logic [OP_BITS-1:0]     operation,
  output cord_t                  st_o
);

  localparam logic [PHASE_BITS-1:0] HALF_P = PHASE_BITS'(1) << (PHASE_BITS - 1);

  logic [PHASE_BITS-1:0]          p;
  logic [PHASE_BITS-1:0]          t;
  logic [31:0]                    a;
  logic signed [CW-1:0]           r;
  logic signed [SAMPLE_BITS+1:0]  tri_v;
  logic signed [SAMPLE_BITS-1:0]  alt;
  logic signed [CW-1:0]           z0;
  cord_t                          st_r;
  cord_t                          st_nxt;

  always_comb begin
    p = phase + phase_offset;
    t = (p > HALF_P) ? (PHASE_BITS'(0) - p) : p;
    tri_v = signed'({1'b0, t[PHASE_BITS-1 -: SAMPLE_BITS+1]}) -
            (SAMPLE_BITS+2)'(S_MAX) - (SAMPLE_BITS+2)'(1);
    a = 32'(p) << (32 - PHASE_BITS);
    r = CW'(signed'(a));
    if (r > QUARTER) begin
      z0 = HALF_C - r;
    end else if (r < -QUARTER) begin
      z0 = -HALF_C - r;
    end else begin
      z0 = r;
    end
    case (op_t'(operation))
      OP_SAW:      alt = {~p[PHASE_BITS-1], p[PHASE_BITS-2 -: SAMPLE_BITS-1]};
      OP_TRIANGLE: alt = (tri_v > (SAMPLE_BITS+2)'(S_MAX)) ? S_MAX :
                         tri_v[SAMPLE_BITS-1:0];
      OP_PULSE:    alt = (p > HALF_P) ? S_MAX : S_MIN;
      default:     alt = '0;
    endcase
    st_nxt.vld  = in_vld;
    st_nxt.sine = (op_t'(operation) == OP_SINE);
    st_nxt.alt  = alt;
    st_nxt.x    = X_START;
    st_nxt.y    = '0;
    st_nxt.z    = z0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r.vld <= st_nxt.vld;
    end
    if (en) begin
      st_r.sine <= st_nxt.sine;
      st_r.alt  <= st_nxt.alt;
      st_r.x    <= st_nxt.x;
      st_r.y    <= st_nxt.y;
      st_r.z    <= st_nxt.z;
    end
  end

  assign st_o = st_r;

endmodule

### sv/ows_cordic_cell.sv
// One CORDIC rotation cell of the sine chain; carries the item along.
module ows_cordic_cell
  import ows_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [IDX_BITS-1:0] idx,
  input  cord_t               st_i,
  output cord_t               st_o
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] at;
  cord_t                st_r;
  cord_t                st_nxt;

  always_comb begin
    dx = st_i.y >>> idx;
    dy = st_i.x >>> idx;
    at = atan_turns(idx);
    st_nxt = st_i;
    if (!st_i.z[CW-1]) begin
      st_nxt.x = st_i.x - dx;
      st_nxt.y = st_i.y + dy;
      st_nxt.z = st_i.z - at;
    end else begin
      st_nxt.x = st_i.x + dx;
      st_nxt.y = st_i.y - dy;
      st_nxt.z = st_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r.vld <= st_nxt.vld;
    end
    if (en) begin
      st_r.sine <= st_nxt.sine;
      st_r.alt  <= st_nxt.alt;
      st_r.x    <= st_nxt.x;
      st_r.y    <= st_nxt.y;
      st_r.z    <= st_nxt.z;
    end
  end

  assign st_o = st_r;

endmodule

### sv/oscillator_waveform_shaper.sv
// Top level: front stage, chain of 24 CORDIC cells and output register.
// Path: the front stage loads an item at the accept edge, then it moves through the
// 24 CORDIC cells and the output register; all of them advance only together.
// Throughput: one item per cycle; the whole chain stalls while the output
// register holds an item that is not taken.
// Reset: synchronous active-low rst_n clears all valid bits; data is not reset.
module oscillator_waveform_shaper
  import ows_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PHASE_BITS-1:0]         in_phase,
  input  logic signed [PHASE_BITS-1:0]  in_phase_offset,
  input  logic [OP_BITS-1:0]            in_operation,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  cord_t                          st [0:CORDIC_STEPS];
  logic [CORDIC_STEPS:0]          vld_vec;
  logic                           adv;
  logic signed [CW-1:0]           y_rnd;
  logic signed [SAMPLE_BITS-1:0]  sine_s;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0]  out_sample_r;
  logic signed [SAMPLE_BITS-1:0]  out_sample_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  ows_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .in_vld       (in_valid),
    .phase        (in_phase),
    .phase_offset (unsigned'(in_phase_offset)),
    .operation    (in_operation),
    .st_o         (st[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    ows_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .idx   (IDX_BITS'(g)),
      .st_i  (st[g]),
      .st_o  (st[g+1])
    );
  end

  for (genvar g = 0; g <= CORDIC_STEPS; g++) begin : g_vld
    assign vld_vec[g] = st[g].vld;
  end

  always_comb begin
    y_rnd = (st[CORDIC_STEPS].y + (CW'(1) <<< (30 - SAMPLE_BITS))) >>> (31 - SAMPLE_BITS);
    if (y_rnd > CW'(S_MAX)) begin
      sine_s = S_MAX;
    end else if (y_rnd < CW'(S_MIN)) begin
      sine_s = S_MIN;
    end else begin
      sine_s = y_rnd[SAMPLE_BITS-1:0];
    end
    out_sample_nxt = st[CORDIC_STEPS].sine ? sine_s : st[CORDIC_STEPS].alt;
    out_valid_nxt  = adv ? st[CORDIC_STEPS].vld : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (adv) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid set after reset");

  a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(vld_vec))
    else $error("cell chain moved during stall");

  a_chain_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && st[CORDIC_STEPS].vld) |=> out_valid)
    else $error("item from last cell lost");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> st[0].vld)
    else $error("accepted item missing from front stage");

endmodule
